// ===== hw/rtl/wasc_pkg.sv =====
// Shared types and constants for the wake-alarm scheduler.
// Holds the slot count, operation and result codes, FSM states and the
// command/status structs between the controller and the datapath.
package wasc_pkg;

  localparam int SLOTS = 16;
  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int TimeW  = 32;
  localparam int CountW = 5;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 1;

  localparam logic [CfgW-1:0] GuardReset = 8'd4;
  localparam logic [CfgW-1:0] LeadReset  = 8'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGuard = 1'b0,
    CfgLead  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OpConnect    = 3'd0,
    OpSetAlarm   = 3'd1,
    OpDisconnect = 3'd2,
    OpTick       = 3'd3,
    OpSuspend    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KindEcho    = 3'd0,
    KindDue     = 3'd1,
    KindWake    = 3'd2,
    KindRelease = 3'd3,
    KindAssert  = 3'd4,
    KindError   = 3'd5,
    KindDone    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StScan,
    StFinish,
    StEmit
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/wake_alarm_scheduler_core.sv =====
// Wake-alarm scheduler core: one request at a time. After acceptance the item takes
// an execute state, then for tick, suspend and set alarm on a valid slot a scan state
// (one slot time memory read per cycle) and a finish state, then an emit state that
// delivers the results while the output does not stall. The next request is taken
// only in the idle state, after the last result of the current one is loaded.
// Asynchronous active-low reset frees all slots, clears count and block, sets guard 4, lead 2.
module wake_alarm_scheduler_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wasc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wasc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   in_operation_i,
  input  logic [3:0]                   in_slot_i,
  input  logic [31:0]                  in_alarm_time_i,
  input  logic [31:0]                  in_now_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   out_kind_o,
  output logic [3:0]                   out_client_o,
  output logic [31:0]                  out_value_o,
  output logic [4:0]                   out_awake_count_o,
  output logic                         out_keep_awake_o,
  output logic                         out_last_o
);
  import wasc_pkg::*;

  // The controller only sequences; all slot state and result queuing
  // live in the datapath.
  cmd_t  cmd;
  stat_t stat;

  // Requests are taken only in the idle state. The output register lets
  // the final result of one request wait while the next is accepted.
  wasc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Results are held as pending flags and delivered in order: release,
  // echo, alarm-due slots ascending, wake or block, then done or error.
  // Count and block outputs show the state after the whole request.
  wasc_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_operation_i    (in_operation_i),
    .in_slot_i         (in_slot_i),
    .in_alarm_time_i   (in_alarm_time_i),
    .in_now_i          (in_now_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_kind_o        (out_kind_o),
    .out_client_o      (out_client_o),
    .out_value_o       (out_value_o),
    .out_awake_count_o (out_awake_count_o),
    .out_keep_awake_o  (out_keep_awake_o),
    .out_last_o        (out_last_o)
  );

endmodule

// ===== hw/rtl/wasc_datapath.sv =====
// Datapath of the wake-alarm scheduler: slot flags, alarm time memory,
// scan pipeline, pending results and the output register.
// Depends on wasc_pkg; driven by commands from wasc_ctrl.
module wasc_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wasc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wasc_pkg::CfgW-1:0]  cfg_data_i,
  input  logic [2:0]                 in_operation_i,
  input  logic [3:0]                 in_slot_i,
  input  logic [31:0]                in_alarm_time_i,
  input  logic [31:0]                in_now_i,
  input  wasc_pkg::cmd_t             cmd_i,
  output wasc_pkg::stat_t            stat_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 out_kind_o,
  output logic [3:0]                 out_client_o,
  output logic [31:0]                out_value_o,
  output logic [4:0]                 out_awake_count_o,
  output logic                       out_keep_awake_o,
  output logic                       out_last_o
);
  import wasc_pkg::*;

  // Configuration.
  logic [CfgW-1:0] guard_q, lead_q;

  // Slot state.
  logic [SLOTS-1:0] used_q, used_d, active_q, active_d;
  logic [CountW-1:0] total_q, total_d;
  logic block_q, block_d;
  logic [TimeW-1:0] time_mem [SLOTS];
  logic mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [TimeW-1:0] mem_wdata;
  logic [TimeW-1:0] rd_data_q;

  // Captured request.
  logic [2:0] op_q;
  logic [3:0] slot_q;
  logic [TimeW-1:0] atime_q, now_q;
  logic [SlotW-1:0] sidx;
  logic slot_ok;

  // Scan pipeline.
  logic [SlotW-1:0] cnt_q, cnt_d, eidx_q;
  logic iss_q, iss_d, evld_q;
  logic best_vld_q, best_vld_d;
  logic [SlotW-1:0] best_idx_q, best_idx_d;
  logic [TimeW-1:0] best_time_q, best_time_d;

  // Pending results.
  logic rel_q, rel_d, echo_q, echo_d, xtra_q, xtra_d;
  logic [SLOTS-1:0] due_q, due_d;
  logic [SlotW-1:0] echo_cl_q, echo_cl_d, xtra_cl_q, xtra_cl_d;
  logic [TimeW-1:0] echo_val_q, echo_val_d, xtra_val_q, xtra_val_d;
  kind_e xtra_kind_q, xtra_kind_d, fin_kind_q, fin_kind_d;

  // Output register.
  logic out_vld_q;
  logic [2:0] kind_q;
  logic [3:0] client_q;
  logic [TimeW-1:0] value_q;
  logic [CountW-1:0] count_q;
  logic keep_q;
  logic last_q;

  logic out_free, load;
  logic free_any, due_any;
  logic [SlotW-1:0] free_idx, due_idx;
  kind_e em_kind;
  logic [3:0] em_client;
  logic [TimeW-1:0] em_value;
  logic em_last;
  logic [TimeW:0] limit;

  assign sidx    = SlotW'(slot_q);
  assign slot_ok = (32'(slot_q) < 32'(SLOTS)) && used_q[sidx];
  assign out_free = !out_vld_q || !out_stall_i;
  assign load     = cmd_i.emit && out_free;
  assign limit    = {1'b0, now_q} + (TimeW + 1)'(guard_q);

  // Lowest free slot and lowest pending due slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    due_any  = 1'b0;
    due_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
      if (due_q[i]) begin
        due_any = 1'b1;
        due_idx = SlotW'(i);
      end
    end
  end

  // Next result in delivery order.
  always_comb begin
    em_last   = 1'b0;
    em_value  = '0;
    em_client = slot_q;
    em_kind   = fin_kind_q;
    priority if (rel_q) begin
      em_kind = KindRelease;
    end else if (echo_q) begin
      em_kind   = KindEcho;
      em_client = 4'(echo_cl_q);
      em_value  = echo_val_q;
    end else if (due_any) begin
      em_kind   = KindDue;
      em_client = 4'(due_idx);
    end else if (xtra_q) begin
      em_kind   = xtra_kind_q;
      em_client = 4'(xtra_cl_q);
      em_value  = xtra_val_q;
    end else begin
      em_last = 1'b1;
    end
  end

  always_comb begin
    used_d      = used_q;
    active_d    = active_q;
    total_d     = total_q;
    block_d     = block_q;
    mem_we      = 1'b0;
    mem_waddr   = sidx;
    mem_wdata   = atime_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    rel_d       = rel_q;
    echo_d      = echo_q;
    echo_cl_d   = echo_cl_q;
    echo_val_d  = echo_val_q;
    due_d       = due_q;
    xtra_d      = xtra_q;
    xtra_cl_d   = xtra_cl_q;
    xtra_val_d  = xtra_val_q;
    xtra_kind_d = xtra_kind_q;
    fin_kind_d  = fin_kind_q;

    if (cmd_i.capture) begin
      rel_d      = 1'b0;
      echo_d     = 1'b0;
      due_d      = '0;
      xtra_d     = 1'b0;
      best_vld_d = 1'b0;
      fin_kind_d = KindDone;
    end

    if (cmd_i.exec) begin
      cnt_d = '0;
      iss_d = stat_o.need_scan;
      unique case (op_q)
        OpConnect: begin
          if (free_any) begin
            used_d[free_idx]   = 1'b1;
            active_d[free_idx] = 1'b1;
            total_d    = total_q + 1'b1;
            mem_we     = 1'b1;
            mem_waddr  = free_idx;
            mem_wdata  = '0;
            echo_d     = 1'b1;
            echo_cl_d  = free_idx;
            echo_val_d = '0;
          end else begin
            fin_kind_d = KindError;
          end
        end
        OpSetAlarm, OpDisconnect: begin
          if (!slot_ok) begin
            fin_kind_d = KindError;
          end else begin
            if (active_q[sidx]) begin
              active_d[sidx] = 1'b0;
              total_d = total_q - 1'b1;
              if (total_d == '0 && block_q) begin
                block_d = 1'b0;
                rel_d   = 1'b1;
              end
            end
            if (op_q == OpSetAlarm) begin
              mem_we     = 1'b1;
              echo_d     = 1'b1;
              echo_cl_d  = sidx;
              echo_val_d = atime_q;
            end else begin
              used_d[sidx] = 1'b0;
            end
          end
        end
        OpTick, OpSuspend: ;
        default: fin_kind_d = KindError;
      endcase
    end

    if (cmd_i.scan) begin
      if (iss_q) begin
        cnt_d = cnt_q + 1'b1;
        iss_d = (32'(cnt_q) != SLOTS - 1);
      end
      if (evld_q) begin
        if (op_q == OpSuspend) begin
          if (used_q[eidx_q] && (!best_vld_q || rd_data_q < best_time_q)) begin
            best_vld_d  = 1'b1;
            best_idx_d  = eidx_q;
            best_time_d = rd_data_q;
          end
        end else if (used_q[eidx_q] && !active_q[eidx_q] && rd_data_q <= now_q) begin
          active_d[eidx_q] = 1'b1;
          total_d = total_q + 1'b1;
          due_d[eidx_q] = 1'b1;
        end
      end
    end

    if (cmd_i.finish && op_q == OpSuspend && best_vld_q) begin
      xtra_cl_d = best_idx_q;
      if ({1'b0, best_time_q} > limit) begin
        xtra_d      = 1'b1;
        xtra_kind_d = KindWake;
        xtra_val_d  = (best_time_q >= TimeW'(lead_q)) ? best_time_q - TimeW'(lead_q) : '0;
      end else if (!block_q) begin
        block_d     = 1'b1;
        xtra_d      = 1'b1;
        xtra_kind_d = KindAssert;
        xtra_val_d  = '0;
      end
    end

    if (load) begin
      priority if (rel_q) begin
        rel_d = 1'b0;
      end else if (echo_q) begin
        echo_d = 1'b0;
      end else if (due_any) begin
        due_d[due_idx] = 1'b0;
      end else if (xtra_q) begin
        xtra_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_q     <= GuardReset;
      lead_q      <= LeadReset;
      used_q      <= '0;
      active_q    <= '0;
      total_q     <= '0;
      block_q     <= 1'b0;
      iss_q       <= 1'b0;
      evld_q      <= 1'b0;
      cnt_q       <= '0;
      best_vld_q  <= 1'b0;
      rel_q       <= 1'b0;
      echo_q      <= 1'b0;
      due_q       <= '0;
      xtra_q      <= 1'b0;
      fin_kind_q  <= KindDone;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CfgGuard) guard_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CfgLead)  lead_q  <= cfg_data_i;
      used_q     <= used_d;
      active_q   <= active_d;
      total_q    <= total_d;
      block_q    <= block_d;
      iss_q      <= iss_d;
      evld_q     <= cmd_i.scan && iss_q;
      cnt_q      <= cnt_d;
      best_vld_q <= best_vld_d;
      rel_q      <= rel_d;
      echo_q     <= echo_d;
      due_q      <= due_d;
      xtra_q     <= xtra_d;
      fin_kind_q <= fin_kind_d;
      if (out_free) out_vld_q <= cmd_i.emit;
    end
  end

  // Count and block are final during emission and travel with each result,
  // so a waiting result keeps them while the next request executes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_operation_i;
      slot_q  <= in_slot_i;
      atime_q <= in_alarm_time_i;
      now_q   <= in_now_i;
    end
    if (mem_we) time_mem[mem_waddr] <= mem_wdata;
    rd_data_q   <= time_mem[cnt_q];
    eidx_q      <= cnt_q;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    echo_cl_q   <= echo_cl_d;
    echo_val_q  <= echo_val_d;
    xtra_cl_q   <= xtra_cl_d;
    xtra_val_q  <= xtra_val_d;
    xtra_kind_q <= xtra_kind_d;
    if (load) begin
      kind_q   <= em_kind;
      client_q <= em_client;
      value_q  <= em_value;
      count_q  <= total_q;
      keep_q   <= block_q;
      last_q   <= em_last;
    end
  end

  assign stat_o.need_scan = (op_q == OpSetAlarm && slot_ok) || op_q == OpTick ||
                            op_q == OpSuspend;
  assign stat_o.scan_done = evld_q && (32'(eidx_q) == SLOTS - 1);
  assign stat_o.emit_last = em_last;
  assign stat_o.out_free  = out_free;

  assign out_valid_o       = out_vld_q;
  assign out_kind_o        = kind_q;
  assign out_client_o      = client_q;
  assign out_value_o       = value_q;
  assign out_awake_count_o = count_q;
  assign out_keep_awake_o  = keep_q;
  assign out_last_o        = last_q;

endmodule

// ===== hw/rtl/wasc_ctrl.sv =====
// Controller state machine of the wake-alarm scheduler.
// Depends on wasc_pkg; sequences wasc_datapath through command signals.
module wasc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wasc_pkg::stat_t stat_i,
  output wasc_pkg::cmd_t  cmd_o
);
  import wasc_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StExec;
      StExec:   state_d = stat_i.need_scan ? StScan : StEmit;
      StScan:   if (stat_i.scan_done) state_d = StFinish;
      StFinish: state_d = StEmit;
      StEmit:   if (stat_i.out_free && stat_i.emit_last) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      StExec:   cmd_o.exec   = 1'b1;
      StScan:   cmd_o.scan   = 1'b1;
      StFinish: cmd_o.finish = 1'b1;
      StEmit:   cmd_o.emit   = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
